// ===== sv/wav_data_chunk_locator_defines.svh =====
// assertion macros for the wav data chunk locator
// no dependencies; included by the modules that carry assertions
`ifndef WAV_DATA_CHUNK_LOCATOR_DEFINES_SVH
`define WAV_DATA_CHUNK_LOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WDCL_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WDCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wdcl_pkg.sv =====
// shared types, constants and helper functions of the wav data chunk locator
// no dependencies; used by every module of the block
package wdcl_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned PosW    = 32;
    localparam int unsigned RateW   = 32;
    localparam int unsigned BitsW   = 16;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [31:0] RIFF_TAG = 32'h5249_4646;
    localparam logic [31:0] WAVE_TAG = 32'h5741_5645;
    localparam logic [31:0] ID_FMT   = 32'h666D_7420;
    localparam logic [31:0] ID_DATA  = 32'h6461_7461;

    localparam logic [RateW-1:0] DEFAULT_RATE = 32'd16000;
    localparam logic [BitsW-1:0] DEFAULT_BITS = 16'd16;
    localparam logic [31:0]      LEN_MASK     = ~32'd3;
    localparam logic [31:0]      FMT_MIN_LEN  = 32'd16;
    localparam logic [PosW-1:0]  MAGIC_LAST   = 32'd11;
    localparam logic [PosW-1:0]  POS_MAX      = 32'hFFFF_FFFF;

    typedef enum logic {
        REG_DEFAULT_RATE = 1'b0,
        REG_DEFAULT_BITS = 1'b1
    } t_reg_sel;

    typedef enum logic [4:0] {
        PH_MAGIC  = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_FMT    = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] file_byte;
        logic             end_of_file;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [31:0]      data_offset;
        logic [31:0]      data_length;
        logic [RateW-1:0] pcm_rate;
        logic [BitsW-1:0] sample_bits;
    } t_out_item;

    typedef struct packed {
        logic [RateW-1:0] default_rate;
        logic [BitsW-1:0] default_bits;
    } t_cfg;

    // byte sel of a four-character tag, first character first
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] sel);
        logic [7:0] res;
        case (sel)
            2'd0:    res = tag[31:24];
            2'd1:    res = tag[23:16];
            2'd2:    res = tag[15:8];
            default: res = tag[7:0];
        endcase
        return res;
    endfunction

    function automatic logic [31:0] byte_swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ===== sv/wdcl_cfg.sv =====
// apb-style register file: default sample rate and default bits per sample
// depends on wdcl_pkg
module wdcl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wdcl_pkg::CfgAddrW-1:0] paddr,
    input  logic [wdcl_pkg::CfgDataW-1:0] pwdata,
    output logic [wdcl_pkg::CfgDataW-1:0] prdata,
    output logic                          pready,
    output wdcl_pkg::t_cfg                o_cfg
);

    logic [wdcl_pkg::RateW-1:0] r_rate;
    logic [wdcl_pkg::BitsW-1:0] r_bits;
    wdcl_pkg::t_reg_sel         reg_sel;
    logic                       wr_en;

    assign reg_sel = wdcl_pkg::t_reg_sel'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= wdcl_pkg::DEFAULT_RATE;
            r_bits <= wdcl_pkg::DEFAULT_BITS;
        end else if (wr_en) begin
            unique case (reg_sel)
                wdcl_pkg::REG_DEFAULT_RATE: begin
                    r_rate <= pwdata[wdcl_pkg::RateW-1:0];
                end
                wdcl_pkg::REG_DEFAULT_BITS: begin
                    r_bits <= pwdata[wdcl_pkg::BitsW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            wdcl_pkg::REG_DEFAULT_RATE: prdata = r_rate;
            wdcl_pkg::REG_DEFAULT_BITS: prdata = {{(wdcl_pkg::CfgDataW-wdcl_pkg::BitsW){1'b0}}, r_bits};
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.default_rate = r_rate;
    assign o_cfg.default_bits = r_bits;

endmodule

// ===== sv/wdcl_parser.sv =====
// byte-wise riff/wave parser: magic check, chunk header walk, fmt capture
// depends on wdcl_pkg and wav_data_chunk_locator_defines.svh
`include "wav_data_chunk_locator_defines.svh"

module wdcl_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  wdcl_pkg::t_in_item  i_item,
    input  wdcl_pkg::t_cfg      i_cfg,
    output wdcl_pkg::t_out_item o_result
);

    localparam logic [4:0] HdrLast   = 5'd7;
    localparam logic [4:0] BodySat   = 5'd16;
    localparam logic [4:0] RateFirst = 5'd4;
    localparam logic [4:0] RateEnd   = 5'd8;
    localparam logic [4:0] BitsLo    = 5'd14;
    localparam logic [4:0] BitsHi    = 5'd15;
    localparam logic [wdcl_pkg::PosW-1:0] TagLen    = 32'd4;
    localparam logic [wdcl_pkg::PosW-1:0] WaveFirst = 32'd8;

    // control
    logic [wdcl_pkg::PosW-1:0]  r_pos, n_pos;
    wdcl_pkg::t_phase           r_phase, n_phase;
    logic [4:0]                 r_count, n_count;
    logic                       r_seen, n_seen;
    logic                       r_fail, n_fail;
    // payload
    logic [55:0]                r_shift, n_shift;
    logic [31:0]                r_remain, n_remain;
    logic [31:0]                r_off, n_off;
    logic [31:0]                r_len, n_len;
    logic [32:0]                r_end, n_end;
    logic [wdcl_pkg::RateW-1:0] r_rate, n_rate;
    logic [wdcl_pkg::BitsW-1:0] r_bits, n_bits;

    logic [7:0]  b;
    logic [63:0] shift_in;
    logic [31:0] hdr_id;
    logic [31:0] hdr_len;
    logic [32:0] pos_inc;
    logic        mismatch;
    logic        just_found;
    logic        len_ok;
    logic        ok;
    logic        last_step;
    logic        at_start;
    logic        in_magic;
    logic        magic_pos;

    assign b        = i_item.file_byte;
    assign shift_in = {r_shift, b};
    assign hdr_id   = shift_in[63:32];
    assign hdr_len  = wdcl_pkg::byte_swap32(shift_in[31:0]);
    assign pos_inc  = {1'b0, r_pos} + 33'd1;

    always_comb begin
        mismatch = 1'b0;
        if (r_pos < TagLen && b != wdcl_pkg::tag_byte(wdcl_pkg::RIFF_TAG, r_pos[1:0])) begin
            mismatch = 1'b1;
        end
        if (r_pos >= WaveFirst && r_pos <= wdcl_pkg::MAGIC_LAST
                && b != wdcl_pkg::tag_byte(wdcl_pkg::WAVE_TAG, r_pos[1:0])) begin
            mismatch = 1'b1;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_count    = r_count;
        n_seen     = r_seen;
        n_fail     = r_fail;
        n_shift    = r_shift;
        n_remain   = r_remain;
        n_off      = r_off;
        n_len      = r_len;
        n_end      = r_end;
        n_rate     = (r_pos == '0) ? i_cfg.default_rate : r_rate;
        n_bits     = (r_pos == '0) ? i_cfg.default_bits : r_bits;
        just_found = 1'b0;

        // saturated position: byte is counted no more and not parsed
        if (r_pos != wdcl_pkg::POS_MAX) begin
            n_pos = pos_inc[31:0];
            unique case (r_phase) inside
                wdcl_pkg::PH_MAGIC: begin
                    if (mismatch) begin
                        n_fail = 1'b1;
                    end
                    if (r_pos == wdcl_pkg::MAGIC_LAST) begin
                        n_phase = (mismatch || r_fail) ? wdcl_pkg::PH_DONE : wdcl_pkg::PH_HEADER;
                        n_count = '0;
                        n_shift = '0;
                    end
                end
                wdcl_pkg::PH_HEADER: begin
                    n_shift = shift_in[55:0];
                    if (r_count == HdrLast) begin
                        n_count = '0;
                        if (hdr_id == wdcl_pkg::ID_DATA) begin
                            n_off      = pos_inc[31:0];
                            n_len      = hdr_len;
                            n_end      = {1'b0, r_pos} + {1'b0, hdr_len} + 33'd1;
                            n_seen     = 1'b1;
                            n_phase    = wdcl_pkg::PH_DONE;
                            just_found = 1'b1;
                        end else if (hdr_len == '0) begin
                            // empty chunk, next header follows at once
                            n_shift = '0;
                        end else begin
                            n_remain = hdr_len;
                            n_phase  = (hdr_id == wdcl_pkg::ID_FMT
                                        && hdr_len >= wdcl_pkg::FMT_MIN_LEN)
                                       ? wdcl_pkg::PH_FMT : wdcl_pkg::PH_SKIP;
                        end
                    end else begin
                        n_count = r_count + 5'd1;
                    end
                end
                wdcl_pkg::PH_FMT, wdcl_pkg::PH_SKIP: begin
                    if (r_phase == wdcl_pkg::PH_FMT) begin
                        if (r_count >= RateFirst && r_count < RateEnd) begin
                            n_rate[{r_count[1:0], 3'b000} +: 8] = b;
                        end else if (r_count == BitsLo) begin
                            n_bits[7:0] = b;
                        end else if (r_count == BitsHi) begin
                            n_bits[15:8] = b;
                        end
                    end
                    if (r_count != BodySat) begin
                        n_count = r_count + 5'd1;
                    end
                    n_remain = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase = wdcl_pkg::PH_HEADER;
                        n_count = '0;
                        n_shift = '0;
                    end
                end
                wdcl_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // chunk fits when its end is within the file; a chunk found on this very
    // byte fits only when empty
    assign len_ok = just_found ? (hdr_len == '0) : (r_end <= pos_inc);
    assign ok     = n_seen && !n_fail && (r_pos >= wdcl_pkg::MAGIC_LAST) && len_ok;

    always_comb begin
        o_result.found       = ok;
        o_result.data_offset = ok ? n_off : '0;
        o_result.data_length = ok ? (n_len & wdcl_pkg::LEN_MASK) : '0;
        o_result.pcm_rate    = n_rate;
        o_result.sample_bits = (n_bits != '0) ? n_bits : i_cfg.default_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= wdcl_pkg::PH_MAGIC;
            r_count <= '0;
            r_seen  <= 1'b0;
            r_fail  <= 1'b0;
        end else if (i_step) begin
            if (i_item.end_of_file) begin
                r_pos   <= '0;
                r_phase <= wdcl_pkg::PH_MAGIC;
                r_count <= '0;
                r_seen  <= 1'b0;
                r_fail  <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_count <= n_count;
                r_seen  <= n_seen;
                r_fail  <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift  <= n_shift;
            r_remain <= n_remain;
            r_off    <= n_off;
            r_len    <= n_len;
            r_end    <= n_end;
            r_rate   <= n_rate;
            r_bits   <= n_bits;
        end
    end

    assign last_step = i_step && i_item.end_of_file;
    assign at_start  = (r_pos == '0) && (r_phase == wdcl_pkg::PH_MAGIC);
    assign in_magic  = (r_phase == wdcl_pkg::PH_MAGIC);
    assign magic_pos = (r_pos <= wdcl_pkg::MAGIC_LAST);

    `WDCL_ASSERT_NEXT(a_eof_restarts, i_clk, i_rst_n, last_step, at_start, "no restart after eof")
    `WDCL_ASSERT(a_magic_window, i_clk, i_rst_n, 1'b1, in_magic == magic_pos, "bad magic window")

endmodule

// ===== sv/wav_data_chunk_locator.sv =====
// wav data chunk locator top level: request registers, parser, config regs
// depends on wdcl_pkg, wdcl_cfg, wdcl_parser, wav_data_chunk_locator_defines.svh
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  --------------------------
//  in        to block   i_in_valid / o_in_stall      i_in_data  (t_in_item)
//  out       from block o_out_valid / i_out_stall    o_out_data (t_out_item)
//  cfg       to block   psel, penable, pwrite/pready paddr, pwdata, prdata
//
// one byte per cycle while the output does not hold back a last byte: each
// request is held in the input register and parsed in a single pass into the
// result register; a result request is made only on the last byte of a file
// synchronous active-low reset clears position, phase and both valid flags;
// config registers reset to 16000 hz and 16 bits
// output stall only holds back a last-of-file byte; other bytes keep moving
`include "wav_data_chunk_locator_defines.svh"

module wav_data_chunk_locator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte requests
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  wdcl_pkg::t_in_item            i_in_data,
    // result requests
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output wdcl_pkg::t_out_item           o_out_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wdcl_pkg::CfgAddrW-1:0] paddr,
    input  logic [wdcl_pkg::CfgDataW-1:0] pwdata,
    output logic [wdcl_pkg::CfgDataW-1:0] prdata,
    output logic                          pready
);

    // first pcm byte can be no earlier than riff header plus one chunk header
    localparam logic [31:0] MinDataOffset = 32'd20;

    wdcl_pkg::t_cfg      cfg;
    wdcl_pkg::t_in_item  r_in;
    logic                r_in_valid;
    wdcl_pkg::t_out_item r_out;
    logic                r_out_valid;
    wdcl_pkg::t_out_item result;
    logic                out_blocked;
    logic                step;
    logic                in_take;

    wdcl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // result register is full and not being taken this cycle
    assign out_blocked = r_out_valid && i_out_stall;
    // held byte moves on unless it would produce a result into a full register
    assign step        = r_in_valid && !(r_in.end_of_file && out_blocked);
    assign o_in_stall  = r_in_valid && !step;
    assign in_take     = i_in_valid && !o_in_stall;

    wdcl_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // result register, loaded only on the last byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.end_of_file) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.end_of_file) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `WDCL_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_in_valid && r_in.end_of_file && o_out_valid && i_out_stall, "input stalled without a blocked last byte")
    `WDCL_ASSERT(a_found_offset, i_clk, i_rst_n, o_out_valid && o_out_data.found, o_out_data.data_offset >= MinDataOffset, "data offset inside the riff header")
    `WDCL_ASSERT(a_not_found_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.data_offset == 32'd0 && o_out_data.data_length == 32'd0, "missing chunk with nonzero position")

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the wav data chunk locator: streams generated wav files
// byte by byte and checks every result request against a built-in tracker
// depends on wdcl_pkg and the wav_data_chunk_locator rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // quiet cycles with no accepted request of any kind before the run is called hung
    localparam int unsigned QUIET_LIMIT   = 2000;
    // cycles let pass after the last result before the final check
    localparam int unsigned SETTLE_CYCLES = 8;
    // random files are added until this many bytes have gone out in all
    localparam int unsigned ITEM_TARGET   = 1650;
    localparam logic [31:0] LIST_TAG      = 32'h4C49_5354;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    wdcl_pkg::t_in_item            i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    wdcl_pkg::t_out_item           o_out_data;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [wdcl_pkg::CfgAddrW-1:0] paddr       = '0;
    logic [wdcl_pkg::CfgDataW-1:0] pwdata      = '0;
    logic [wdcl_pkg::CfgDataW-1:0] prdata;
    logic                          pready;

    wav_data_chunk_locator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns period
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // locator tracker: mirrors the parser state one byte at a time
    // ------------------------------------------------------------------
    logic [31:0] reg_rate;
    logic [15:0] reg_bits;

    logic [31:0]      loc_pos;
    wdcl_pkg::t_phase loc_phase;
    logic [63:0]      loc_hdr;
    logic [32:0]      loc_left;
    logic [31:0]      loc_base;
    logic [31:0]      loc_rate;
    logic [15:0]      loc_bits;
    logic [31:0]      loc_off;
    logic [31:0]      loc_len;
    logic             loc_has_data;
    logic             loc_bad_magic;

    // results owed by the block, oldest first
    wdcl_pkg::t_out_item pending_locations[$];
    int unsigned         mismatch_count = 0;
    int unsigned         bytes_sent     = 0;
    int unsigned         files_sent     = 0;

    // idling switches for the byte sender and the result receiver
    bit          in_idle_on  = 1'b1;
    bit          out_idle_on = 1'b1;

    // bytes of the file being built
    logic [7:0]  file_buf[$];

    function automatic void clear_tracker();
        loc_pos       = '0;
        loc_phase     = wdcl_pkg::PH_MAGIC;
        loc_hdr       = '0;
        loc_left      = '0;
        loc_base      = '0;
        loc_rate      = reg_rate;
        loc_bits      = reg_bits;
        loc_off       = '0;
        loc_len       = '0;
        loc_has_data  = 1'b0;
        loc_bad_magic = 1'b0;
    endfunction

    function automatic void parse_into_tracker(input logic [31:0] idx, input logic [7:0] b);
        logic [31:0] rel;
        logic [31:0] id;
        logic [31:0] len;
        unique case (loc_phase) inside
            wdcl_pkg::PH_MAGIC: begin
                // riff at bytes 0..3, wave at 8..11, size field ignored
                if (idx < 4 && b != wdcl_pkg::RIFF_TAG[8*(3-idx[1:0]) +: 8])
                    loc_bad_magic = 1'b1;
                if (idx >= 8 && idx < 12 && b != wdcl_pkg::WAVE_TAG[8*(3-idx[1:0]) +: 8])
                    loc_bad_magic = 1'b1;
                if (idx == wdcl_pkg::MAGIC_LAST) begin
                    loc_phase = loc_bad_magic ? wdcl_pkg::PH_DONE : wdcl_pkg::PH_HEADER;
                    loc_base  = 32'd12;
                    loc_hdr   = '0;
                end
            end
            wdcl_pkg::PH_HEADER: begin
                loc_hdr = {loc_hdr[55:0], b};
                rel     = idx - loc_base;
                if (rel == 32'd7) begin
                    id  = loc_hdr[63:32];
                    // length field is little-endian
                    len = {loc_hdr[7:0], loc_hdr[15:8], loc_hdr[23:16], loc_hdr[31:24]};
                    if (id == wdcl_pkg::ID_DATA) begin
                        loc_off      = idx + 32'd1;
                        loc_len      = len;
                        loc_has_data = 1'b1;
                        loc_phase    = wdcl_pkg::PH_DONE;
                    end else if (len == '0) begin
                        loc_base = idx + 32'd1;
                        loc_hdr  = '0;
                    end else begin
                        loc_left  = {1'b0, len};
                        loc_phase = (id == wdcl_pkg::ID_FMT && len >= wdcl_pkg::FMT_MIN_LEN)
                                    ? wdcl_pkg::PH_FMT : wdcl_pkg::PH_SKIP;
                    end
                end
            end
            wdcl_pkg::PH_FMT, wdcl_pkg::PH_SKIP: begin
                if (loc_phase == wdcl_pkg::PH_FMT) begin
                    rel = idx - loc_base - 32'd8;
                    if (rel >= 4 && rel < 8)
                        loc_rate[8*rel[1:0] +: 8] = b;
                    else if (rel == 32'd14)
                        loc_bits[7:0] = b;
                    else if (rel == 32'd15)
                        loc_bits[15:8] = b;
                end
                loc_left = loc_left - 33'd1;
                if (loc_left == '0) begin
                    loc_phase = wdcl_pkg::PH_HEADER;
                    loc_base  = idx + 32'd1;
                    loc_hdr   = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // advances the tracker by one byte; returns 1 with the location on the last byte
    function automatic bit track_byte(input wdcl_pkg::t_in_item req,
                                      output wdcl_pkg::t_out_item loc);
        logic [31:0] idx;
        logic [32:0] file_len;
        logic        ok;
        idx = loc_pos;
        loc = '0;
        // defaults are picked up at the first byte of every file
        if (idx == '0) begin
            loc_rate = reg_rate;
            loc_bits = reg_bits;
        end
        if (idx != wdcl_pkg::POS_MAX) begin
            parse_into_tracker(idx, req.file_byte);
            loc_pos = idx + 32'd1;
        end
        if (!req.end_of_file)
            return 1'b0;
        file_len = {1'b0, idx} + 33'd1;
        ok = loc_has_data && !loc_bad_magic && file_len >= 33'd12
             && ({1'b0, loc_off} + {1'b0, loc_len}) <= file_len;
        loc.found       = ok;
        loc.data_offset = ok ? loc_off : '0;
        loc.data_length = ok ? (loc_len & wdcl_pkg::LEN_MASK) : '0;
        loc.pcm_rate    = loc_rate;
        loc.sample_bits = (loc_bits != '0) ? loc_bits : reg_bits;
        clear_tracker();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall per result, field-by-field compare
    // ------------------------------------------------------------------
    function automatic void compare_location(input wdcl_pkg::t_out_item want,
                                             input wdcl_pkg::t_out_item got);
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatch_count++;
        end
        if (got.data_offset !== want.data_offset) begin
            $error("data_offset: expected %0d, got %0d", want.data_offset, got.data_offset);
            mismatch_count++;
        end
        if (got.data_length !== want.data_length) begin
            $error("data_length: expected %0d, got %0d", want.data_length, got.data_length);
            mismatch_count++;
        end
        if (got.pcm_rate !== want.pcm_rate) begin
            $error("pcm_rate: expected %0d, got %0d", want.pcm_rate, got.pcm_rate);
            mismatch_count++;
        end
        if (got.sample_bits !== want.sample_bits) begin
            $error("sample_bits: expected %0d, got %0d", want.sample_bits, got.sample_bits);
            mismatch_count++;
        end
    endfunction

    int unsigned stall_left = 0;

    // all signals read here hold their pre-edge values
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (pending_locations.size() == 0) begin
                $error("result request with no location expected");
                mismatch_count++;
            end else begin
                compare_location(pending_locations.pop_front(), o_out_data);
            end
            // stall for the next result is drawn now and held until it shows up
            stall_left  = out_idle_on ? $urandom_range(0, 4) : 0;
            i_out_stall <= (stall_left != 0);
        end else if (o_out_valid) begin
            stall_left  = stall_left - 1;
            i_out_stall <= (stall_left != 0);
        end
    end

    // watchdog: any accepted byte, result or register write restarts the count
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite && pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // byte sender; every task here returns right after a rising edge
    // ------------------------------------------------------------------
    // valid stays high after acceptance, so the caller must either send
    // again or drop valid in the same step
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int                  gap;
        wdcl_pkg::t_in_item  req;
        wdcl_pkg::t_out_item loc;
        gap             = in_idle_on ? $urandom_range(0, 4) : 0;
        req.file_byte   = b;
        req.end_of_file = eof;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (track_byte(req, loc))
            pending_locations.push_back(loc);
        bytes_sent++;
    endtask

    task automatic play_file();
        int n;
        n = file_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(file_buf[i], i == n - 1);
        file_buf.delete();
        files_sent++;
    endtask

    // stop sending and wait for every owed result
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (pending_locations.size() != 0) @(posedge i_clk);
    endtask

    // two-phase register write, only with the block idle
    task automatic write_reg(input wdcl_pkg::t_reg_sel sel, input logic [31:0] value);
        pause_until_drained();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wdcl_pkg::CfgAddrW'({sel, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            wdcl_pkg::REG_DEFAULT_RATE: reg_rate = value;
            wdcl_pkg::REG_DEFAULT_BITS: reg_bits = value[15:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------
    function automatic void put_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_buf.push_back(tag[8*i +: 8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_buf.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_le16(input logic [15:0] v);
        file_buf.push_back(v[7:0]);
        file_buf.push_back(v[15:8]);
    endfunction

    function automatic void put_fill(input int unsigned n);
        repeat (n) file_buf.push_back(8'($urandom));
    endfunction

    function automatic void put_wav_head();
        put_tag(wdcl_pkg::RIFF_TAG);
        put_le32($urandom);
        put_tag(wdcl_pkg::WAVE_TAG);
    endfunction

    function automatic void put_chunk_hdr(input logic [31:0] id, input logic [31:0] len);
        put_tag(id);
        put_le32(len);
    endfunction

    // rate at body bytes 4..7, bits at 14..15; short chunks carry filler only
    function automatic void put_fmt(input int unsigned len, input logic [31:0] rate,
                                    input logic [15:0] bits);
        put_chunk_hdr(wdcl_pkg::ID_FMT, len);
        if (len >= 16) begin
            put_fill(4);
            put_le32(rate);
            put_fill(6);
            put_le16(bits);
            put_fill(len - 16);
        end else begin
            put_fill(len);
        end
    endfunction

    function automatic logic [15:0] rand_bits();
        return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_id();
        return ($urandom_range(0, 1) == 0) ? LIST_TAG : $urandom;
    endfunction

    // mostly well-formed files with random chunk mix, some broken or pure noise
    function automatic void gen_random_file();
        int unsigned kind;
        int unsigned len;
        int unsigned body;
        int unsigned cut;
        int unsigned pick;
        logic [31:0] dlen;
        kind = $urandom_range(0, 99);
        if (kind >= 93) begin
            put_fill($urandom_range(1, 30));
            return;
        end
        put_wav_head();
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3)) inside
                0, 1: put_fmt($urandom_range(16, 20), $urandom, rand_bits());
                2: put_fmt($urandom_range(0, 15), $urandom, rand_bits());
                default: begin
                    len = $urandom_range(0, 6);
                    put_chunk_hdr(rand_id(), len);
                    put_fill(len);
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0) begin
            dlen = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 16));
            put_chunk_hdr(wdcl_pkg::ID_DATA, dlen);
            body = (dlen > 16) ? $urandom_range(0, 16) : dlen;
            case ($urandom_range(0, 3))
                0: body = $urandom_range(0, body);           // body cut short
                1: body = body + $urandom_range(1, 6);       // trailing chunks or junk
                default: ;
            endcase
            put_fill(body);
        end
        if (kind >= 75 && kind < 85) begin
            // one flipped bit somewhere in riff or wave
            pick = $urandom_range(0, 7);
            pick = (pick < 4) ? pick : pick + 4;
            file_buf[pick] = file_buf[pick] ^ (8'd1 << $urandom_range(0, 7));
        end else if (kind >= 85) begin
            cut = $urandom_range(1, file_buf.size());
            file_buf = file_buf[0:cut-1];
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_layouts();
        // smallest valid file: empty data chunk, no fmt
        put_wav_head();
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd0);
        play_file();
        // full fmt, odd data length gets rounded down
        put_wav_head();
        put_fmt(16, 32'd44100, 16'd24);
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd7);
        put_fill(7);
        play_file();
        // fmt with zero bits falls back to the default, extreme byte values in rate
        put_wav_head();
        put_fmt(18, 32'hFF00_FF00, 16'd0);
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd4);
        put_fill(4);
        play_file();
        // short fmt is skipped, empty foreign chunk, trailing bytes after data
        put_wav_head();
        put_fmt(8, $urandom, 16'd8);
        put_chunk_hdr(LIST_TAG, 32'd0);
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd2);
        put_fill(5);
        play_file();
        // data chunk overruns the file
        put_wav_head();
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'hFFFF_FFFF);
        put_fill(3);
        play_file();
        // no data chunk at all
        put_wav_head();
        put_chunk_hdr(LIST_TAG, 32'd3);
        put_fill(3);
        play_file();
        // partial chunk header at the end
        put_wav_head();
        put_fill(5);
        play_file();
        // under 12 bytes, and single-byte files at both extremes
        put_wav_head();
        file_buf = file_buf[0:10];
        play_file();
        file_buf.push_back(8'hFF);
        play_file();
        file_buf.push_back(8'h00);
        play_file();
        // bad riff, then bad wave
        put_wav_head();
        file_buf[0] = 8'h72;
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd0);
        play_file();
        put_wav_head();
        file_buf[11] = 8'h00;
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd0);
        play_file();
    endtask

    task automatic test_register_extremes();
        logic [31:0] rates[3];
        logic [15:0] bits[3];
        rates = '{32'd0, 32'hFFFF_FFFF, $urandom};
        bits  = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 65535))};
        for (int i = 0; i < 3; i++) begin
            write_reg(wdcl_pkg::REG_DEFAULT_RATE, rates[i]);
            write_reg(wdcl_pkg::REG_DEFAULT_BITS, {16'd0, bits[i]});
            // no fmt: both defaults show through
            put_wav_head();
            put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd1);
            put_fill(1);
            play_file();
            // fmt with zero bits: default bits only
            put_wav_head();
            put_fmt(16, $urandom, 16'd0);
            put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd0);
            play_file();
            gen_random_file();
            play_file();
        end
    endtask

    task automatic test_zero_default_bits();
        write_reg(wdcl_pkg::REG_DEFAULT_BITS, 32'd0);
        put_wav_head();
        put_fmt(16, $urandom, 16'd0);
        put_chunk_hdr(wdcl_pkg::ID_DATA, 32'd4);
        put_fill(4);
        play_file();
        put_wav_head();
        put_fmt(16, $urandom, 16'd0);
        put_fill(2);
        play_file();
        write_reg(wdcl_pkg::REG_DEFAULT_BITS, {16'd0, wdcl_pkg::DEFAULT_BITS});
        write_reg(wdcl_pkg::REG_DEFAULT_RATE, wdcl_pkg::DEFAULT_RATE);
    endtask

    task automatic test_pressure();
        // sender waits out every result before the next file
        in_idle_on  = 1'b0;
        out_idle_on = 1'b1;
        repeat (3) begin
            gen_random_file();
            play_file();
            pause_until_drained();
        end
        // full-rate burst, no idling either side
        out_idle_on = 1'b0;
        repeat (4) begin
            gen_random_file();
            play_file();
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    task automatic test_random_files();
        while (bytes_sent < ITEM_TARGET) begin
            // now and then a stretch with no idling on one or both sides
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            if (files_sent % 8 == 7) begin
                write_reg(wdcl_pkg::REG_DEFAULT_RATE, $urandom);
                write_reg(wdcl_pkg::REG_DEFAULT_BITS, 32'($urandom_range(1, 65535)));
            end
            gen_random_file();
            play_file();
        end
    endtask

    initial begin
        reg_rate = wdcl_pkg::DEFAULT_RATE;
        reg_bits = wdcl_pkg::DEFAULT_BITS;
        clear_tracker();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_layouts();
        test_register_extremes();
        test_zero_default_bits();
        test_pressure();
        test_random_files();

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_locations.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_locations.size() != 0)
                $error("%0d expected locations never arrived", pending_locations.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wdcl_pkg.sv
sv/wdcl_cfg.sv
sv/wdcl_parser.sv
sv/wav_data_chunk_locator.sv
bench/testbench.sv
